[src/scpc_pkg.sv]
package scpc_pkg;

  // Pixel and register geometry
  localparam int unsigned PixW     = 8;
  localparam int unsigned SatW     = 4;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned ChromaW  = 18;
  localparam int unsigned SatProdW = 12;

  typedef logic [PixW-1:0]     pix_t;
  typedef logic [SatW-1:0]     sat_t;
  typedef logic [ChromaW-1:0]  chroma_t;
  typedef logic [SatProdW-1:0] sat_prod_t;

  // Register indexes (byte address is 4 * index)
  localparam logic [RegIdxW-1:0] REG_CB_LOW   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CB_HIGH  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CR_LOW   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CR_HIGH  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SAT_LOW  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_SAT_HIGH = 3'd5;

  // Register reset values
  localparam pix_t RST_CB_LOW   = 8'd60;
  localparam pix_t RST_CB_HIGH  = 8'd130;
  localparam pix_t RST_CR_LOW   = 8'd130;
  localparam pix_t RST_CR_HIGH  = 8'd165;
  localparam sat_t RST_SAT_LOW  = 4'd1;
  localparam sat_t RST_SAT_HIGH = 4'd9;

  // Daylight rule thresholds
  localparam pix_t DAY_R_MIN     = 8'd50;
  localparam pix_t DAY_G_MIN     = 8'd40;
  localparam pix_t DAY_B_MIN     = 8'd20;
  localparam pix_t DAY_SPREAD    = 8'd10;
  localparam pix_t DAY_RG_MIN    = 8'd10;

  // Bright-light rule thresholds
  localparam pix_t BRT_R_MIN     = 8'd220;
  localparam pix_t BRT_G_MIN     = 8'd210;
  localparam pix_t BRT_B_MIN     = 8'd170;
  localparam pix_t BRT_RG_MAX    = 8'd15;

  // Chroma coefficients scaled by 1000; bias holds 128 * 1000 plus half an LSB
  localparam chroma_t CHROMA_BIAS = 18'd128500;
  localparam chroma_t CB_R_COEF   = 18'd148;
  localparam chroma_t CB_G_COEF   = 18'd291;
  localparam chroma_t CB_B_COEF   = 18'd439;
  localparam chroma_t CR_R_COEF   = 18'd439;
  localparam chroma_t CR_G_COEF   = 18'd368;
  localparam chroma_t CR_B_COEF   = 18'd71;
  localparam chroma_t CHROMA_SCALE = 18'd1000;

  localparam sat_prod_t SAT_SCALE = 12'd10;

  // First stage: rule result, saturation terms and scaled chroma sums
  typedef struct packed {
    logic    rgb_ok;
    pix_t    cmax;
    pix_t    del;
    chroma_t cb_sum;
    chroma_t cr_sum;
  } s1_t;

  // Second stage: the three independent verdicts
  typedef struct packed {
    logic rgb_ok;
    logic chroma_ok;
    logic sat_ok;
  } s2_t;

endpackage

[src/scpc_if.sv]
interface scpc_pix_if;
  import scpc_pkg::*;

  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface scpc_flag_if;
  logic valid;
  logic ready;
  logic is_skin;

  modport source (output valid, output is_skin, input ready);
  modport sink   (input valid, input is_skin, output ready);
endinterface

[src/skin_color_pixel_classifier.sv]
// Channel  | Dir | Payload               | Handshake
// pix_i    | in  | red, green, blue (8b) | valid / ready
// skin_o   | out | is_skin (1b)          | valid / ready
// cfg      | in  | APB, 6 regs at 4*i    | psel / penable, pready tied high
//
// Three register stages: rules and chroma sums, window and saturation
// compares, output flag. One beat per clock while skin_o is not stalled;
// an accepted beat passes stage 1 and stage 2 into the output flag register.
// Each stage holds while its successor is full and stalled, and takes a new
// beat as soon as it is empty or moving, so bubbles close up behind a
// stalled output. Reset clears stage valid bits, loads register defaults.
module skin_color_pixel_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  scpc_pix_if.sink                   pix_i,
  scpc_flag_if.source                skin_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scpc_pkg::AddrW-1:0] paddr,
  input  logic [scpc_pkg::DataW-1:0] pwdata,
  output logic [scpc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import scpc_pkg::*;

  // Configuration registers
  pix_t cb_low_q, cb_high_q, cr_low_q, cr_high_q;
  sat_t sat_low_q, sat_high_q;

  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_low_q   <= RST_CB_LOW;
      cb_high_q  <= RST_CB_HIGH;
      cr_low_q   <= RST_CR_LOW;
      cr_high_q  <= RST_CR_HIGH;
      sat_low_q  <= RST_SAT_LOW;
      sat_high_q <= RST_SAT_HIGH;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CB_LOW:   cb_low_q   <= pwdata[PixW-1:0];
        REG_CB_HIGH:  cb_high_q  <= pwdata[PixW-1:0];
        REG_CR_LOW:   cr_low_q   <= pwdata[PixW-1:0];
        REG_CR_HIGH:  cr_high_q  <= pwdata[PixW-1:0];
        REG_SAT_LOW:  sat_low_q  <= pwdata[SatW-1:0];
        REG_SAT_HIGH: sat_high_q <= pwdata[SatW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_CB_LOW:   prdata = DataW'(cb_low_q);
      REG_CB_HIGH:  prdata = DataW'(cb_high_q);
      REG_CR_LOW:   prdata = DataW'(cr_low_q);
      REG_CR_HIGH:  prdata = DataW'(cr_high_q);
      REG_SAT_LOW:  prdata = DataW'(sat_low_q);
      REG_SAT_HIGH: prdata = DataW'(sat_high_q);
      default:      prdata = '0;
    endcase
  end

  // Stage flow control
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3        = !v3_q || skin_o.ready;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pix_i.ready = rdy1;

  // Stage 1: RGB rules, max/min, chroma sums
  s1_t  s1_d, s1_q;
  pix_t r, g, b, mx, mn, rg_abs;
  logic day, bright;

  always_comb begin
    r      = pix_i.red;
    g      = pix_i.green;
    b      = pix_i.blue;
    mx     = (r > g) ? r : g;
    mx     = (mx > b) ? mx : b;
    mn     = (r < g) ? r : g;
    mn     = (mn < b) ? mn : b;
    rg_abs = (r > g) ? (r - g) : (g - r);

    day    = (r > DAY_R_MIN) && (g > DAY_G_MIN) && (b > DAY_B_MIN) &&
             ((mx - mn) > DAY_SPREAD) && (rg_abs >= DAY_RG_MIN) &&
             (r > g) && (r > b);
    bright = (r > BRT_R_MIN) && (g > BRT_G_MIN) && (b > BRT_B_MIN) &&
             (rg_abs < BRT_RG_MAX) && (r > b) && (g > b);

    s1_d.rgb_ok = day || bright;
    s1_d.cmax   = mx;
    s1_d.del    = mx - mn;
    // Sums stay positive and below 2^18 for all pixels; wrap is harmless
    s1_d.cb_sum = CHROMA_BIAS + ChromaW'(b) * CB_B_COEF
                - ChromaW'(r) * CB_R_COEF - ChromaW'(g) * CB_G_COEF;
    s1_d.cr_sum = CHROMA_BIAS + ChromaW'(r) * CR_R_COEF
                - ChromaW'(g) * CR_G_COEF - ChromaW'(b) * CR_B_COEF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: chroma windows as scaled bounds, saturation by cross-multiply
  s2_t       s2_d, s2_q;
  chroma_t   cb_lo_thr, cb_hi_thr, cr_lo_thr, cr_hi_thr;
  sat_prod_t del_x10, sat_lo_x, sat_hi_x;

  always_comb begin
    // floor(sum/1000) >= L  <=>  sum >= 1000*L
    // floor(sum/1000) <= H  <=>  sum <  1000*(H+1)
    cb_lo_thr = ChromaW'(cb_low_q) * CHROMA_SCALE;
    cb_hi_thr = (ChromaW'(cb_high_q) + ChromaW'(1)) * CHROMA_SCALE;
    cr_lo_thr = ChromaW'(cr_low_q) * CHROMA_SCALE;
    cr_hi_thr = (ChromaW'(cr_high_q) + ChromaW'(1)) * CHROMA_SCALE;

    del_x10  = SatProdW'(s1_q.del) * SAT_SCALE;
    sat_lo_x = SatProdW'(sat_low_q) * SatProdW'(s1_q.cmax);
    sat_hi_x = SatProdW'(sat_high_q) * SatProdW'(s1_q.cmax);

    s2_d.rgb_ok    = s1_q.rgb_ok;
    s2_d.chroma_ok = (s1_q.cb_sum >= cb_lo_thr) && (s1_q.cb_sum < cb_hi_thr) &&
                     (s1_q.cr_sum >= cr_lo_thr) && (s1_q.cr_sum < cr_hi_thr);
    // Black pixel fails saturation
    s2_d.sat_ok    = (s1_q.cmax != '0) && (del_x10 >= sat_lo_x) &&
                     (del_x10 <= sat_hi_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: combine verdicts into the output register
  logic skin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      skin_q <= s2_q.rgb_ok && s2_q.chroma_ok && s2_q.sat_ok;
    end
  end

  assign skin_o.valid   = v3_q;
  assign skin_o.is_skin = skin_q;

  // An accepted beat always lands in stage 1
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> v1_q)
    else $error("accepted pixel beat not captured in stage 1");

  // A blocked stage 1 holds its contents
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(s1_q)))
    else $error("stage 1 changed while blocked");

  // An empty pipe never refuses input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q && !v3_q) |-> pix_i.ready)
    else $error("empty pipeline not ready for input");

  // With a nonzero saturation floor, a pixel with zero spread fails saturation
  a_s2_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2 && s1_q.del == '0 && sat_low_q != '0) |=> !s2_q.sat_ok)
    else $error("gray pixel passed a nonzero saturation floor");

endmodule
